// ===== rtl/tgpll_pkg.sv =====
// Shared types, constants and the microcode of the grid PLL.
// No dependencies; tgpll_ctrl, tgpll_dp and the top level import this package.
package tgpll_pkg;

    localparam int SAMPLE_WIDTH = 16;
    localparam int STEP_W       = 6;
    localparam int ACC_W        = 68;
    localparam int OP_W         = 33;
    localparam int PROD_W       = 2 * OP_W;
    localparam int GAIN_SH      = SAMPLE_WIDTH + 7;

    localparam logic [16:0] INV_SQRT3_Q16 = 17'd37837;
    localparam logic signed [15:0] COS_RESET = 16'sh7fff;

    localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;
    localparam longint unsigned ONE_Q30     = 64'd1073741824;

    // config register indexes
    localparam int CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] CFG_B0  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_B1  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_B2  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_A1  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_A2  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_KP  = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_KI  = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_PER = 3'd7;

    // multiplier operand A
    localparam logic [3:0] OPA_NONE = 4'd0;
    localparam logic [3:0] OPA_DIFF = 4'd1;
    localparam logic [3:0] OPA_A1   = 4'd2;
    localparam logic [3:0] OPA_A2   = 4'd3;
    localparam logic [3:0] OPA_B0   = 4'd4;
    localparam logic [3:0] OPA_B1   = 4'd5;
    localparam logic [3:0] OPA_B2   = 4'd6;
    localparam logic [3:0] OPA_UA   = 4'd7;
    localparam logic [3:0] OPA_UB   = 4'd8;
    localparam logic [3:0] OPA_KI   = 4'd9;
    localparam logic [3:0] OPA_KP   = 4'd10;
    localparam logic [3:0] OPA_FREQ = 4'd11;

    // multiplier operand B
    localparam logic [3:0] OPB_NONE = 4'd0;
    localparam logic [3:0] OPB_ISQ3 = 4'd1;
    localparam logic [3:0] OPB_D1   = 4'd2;
    localparam logic [3:0] OPB_D2   = 4'd3;
    localparam logic [3:0] OPB_W0   = 4'd4;
    localparam logic [3:0] OPB_COS  = 4'd5;
    localparam logic [3:0] OPB_SIN  = 4'd6;
    localparam logic [3:0] OPB_ERR  = 4'd7;
    localparam logic [3:0] OPB_PER  = 4'd8;

    // writeback targets
    localparam logic [3:0] WB_NONE  = 4'd0;
    localparam logic [3:0] WB_BETA  = 4'd1;
    localparam logic [3:0] WB_W0    = 4'd2;
    localparam logic [3:0] WB_Y     = 4'd3;
    localparam logic [3:0] WB_D     = 4'd4;
    localparam logic [3:0] WB_Q     = 4'd5;
    localparam logic [3:0] WB_INT   = 4'd6;
    localparam logic [3:0] WB_FREQ  = 4'd7;
    localparam logic [3:0] WB_PHASE = 4'd8;
    localparam logic [3:0] WB_SIN   = 4'd9;
    localparam logic [3:0] WB_COS   = 4'd10;

    typedef struct packed {
        logic signed [SAMPLE_WIDTH-1:0] phase_a;
        logic signed [SAMPLE_WIDTH-1:0] phase_b;
        logic signed [SAMPLE_WIDTH-1:0] phase_c;
    } t_in_item;

    typedef struct packed {
        logic signed [SAMPLE_WIDTH-1:0] direct_axis;
        logic signed [SAMPLE_WIDTH-1:0] quadrature_axis;
        logic signed [31:0]             frequency_estimate;
        logic [15:0]                    phase_angle;
        logic signed [15:0]             sine_out;
        logic signed [15:0]             cosine_out;
    } t_out_item;

    typedef struct packed {
        logic       mul_en;
        logic [3:0] opa;
        logic [3:0] opb;
        logic       acc_en;
        logic       acc_clr;
        logic       acc_sub;
        logic [3:0] wb;
        logic       ch;      // 0: alpha filter, 1: beta filter
        logic       last;
    } t_uop;

    typedef struct packed {
        logic load_in;
        logic out_load;
        t_uop uop;
    } t_cmd;

    localparam t_uop UOP_NOP = '0;

    function automatic t_uop mk(input logic mul_en, input logic [3:0] opa,
                                input logic [3:0] opb, input logic acc_en,
                                input logic acc_clr, input logic acc_sub,
                                input logic [3:0] wb, input logic ch,
                                input logic last);
        t_uop u;
        u.mul_en  = mul_en;
        u.opa     = opa;
        u.opb     = opb;
        u.acc_en  = acc_en;
        u.acc_clr = acc_clr;
        u.acc_sub = acc_sub;
        u.wb      = wb;
        u.ch      = ch;
        u.last    = last;
        return u;
    endfunction

    // one biquad: feedback sum, w0, then numerator sum and output
    function automatic t_uop filt_uop(input logic [STEP_W-1:0] f, input logic ch);
        t_uop u;
        u = UOP_NOP;
        unique case (f)
            6'd0:    u = mk(1'b1, OPA_A1, OPB_D1, 1'b0, 1'b0, 1'b0, WB_NONE, ch, 1'b0);
            6'd1:    u = mk(1'b1, OPA_A2, OPB_D2, 1'b1, 1'b1, 1'b0, WB_NONE, ch, 1'b0);
            6'd2:    u = mk(1'b0, OPA_NONE, OPB_NONE, 1'b1, 1'b0, 1'b0, WB_NONE, ch, 1'b0);
            6'd3:    u = mk(1'b0, OPA_NONE, OPB_NONE, 1'b0, 1'b0, 1'b0, WB_W0, ch, 1'b0);
            6'd4:    u = mk(1'b1, OPA_B0, OPB_W0, 1'b0, 1'b0, 1'b0, WB_NONE, ch, 1'b0);
            6'd5:    u = mk(1'b1, OPA_B1, OPB_D1, 1'b1, 1'b1, 1'b0, WB_NONE, ch, 1'b0);
            6'd6:    u = mk(1'b1, OPA_B2, OPB_D2, 1'b1, 1'b0, 1'b0, WB_NONE, ch, 1'b0);
            6'd7:    u = mk(1'b0, OPA_NONE, OPB_NONE, 1'b1, 1'b0, 1'b0, WB_NONE, ch, 1'b0);
            6'd8:    u = mk(1'b0, OPA_NONE, OPB_NONE, 1'b0, 1'b0, 1'b0, WB_Y, ch, 1'b0);
            default: u = UOP_NOP;
        endcase
        return u;
    endfunction

    localparam logic [STEP_W-1:0] LAST_STEP = 6'd40;

    function automatic t_uop ucode(input logic [STEP_W-1:0] step);
        t_uop u;
        u = UOP_NOP;
        if (step >= 6'd3 && step <= 6'd11) begin
            u = filt_uop(step - 6'd3, 1'b0);
        end else if (step >= 6'd12 && step <= 6'd20) begin
            u = filt_uop(step - 6'd12, 1'b1);
        end else begin
            unique case (step)
                6'd0:  u = mk(1'b1, OPA_DIFF, OPB_ISQ3, 1'b0, 1'b0, 1'b0, WB_NONE, 1'b0, 1'b0);
                6'd1:  u = mk(1'b0, OPA_NONE, OPB_NONE, 1'b1, 1'b1, 1'b0, WB_NONE, 1'b0, 1'b0);
                6'd2:  u = mk(1'b0, OPA_NONE, OPB_NONE, 1'b0, 1'b0, 1'b0, WB_BETA, 1'b0, 1'b0);
                6'd21: u = mk(1'b1, OPA_UA, OPB_COS, 1'b0, 1'b0, 1'b0, WB_NONE, 1'b0, 1'b0);
                6'd22: u = mk(1'b1, OPA_UB, OPB_SIN, 1'b1, 1'b1, 1'b0, WB_NONE, 1'b0, 1'b0);
                6'd23: u = mk(1'b0, OPA_NONE, OPB_NONE, 1'b1, 1'b0, 1'b0, WB_NONE, 1'b0, 1'b0);
                6'd24: u = mk(1'b0, OPA_NONE, OPB_NONE, 1'b0, 1'b0, 1'b0, WB_D, 1'b0, 1'b0);
                6'd25: u = mk(1'b1, OPA_UB, OPB_COS, 1'b0, 1'b0, 1'b0, WB_NONE, 1'b0, 1'b0);
                6'd26: u = mk(1'b1, OPA_UA, OPB_SIN, 1'b1, 1'b1, 1'b0, WB_NONE, 1'b0, 1'b0);
                6'd27: u = mk(1'b0, OPA_NONE, OPB_NONE, 1'b1, 1'b0, 1'b1, WB_NONE, 1'b0, 1'b0);
                6'd28: u = mk(1'b0, OPA_NONE, OPB_NONE, 1'b0, 1'b0, 1'b0, WB_Q, 1'b0, 1'b0);
                6'd29: u = mk(1'b1, OPA_KI, OPB_ERR, 1'b0, 1'b0, 1'b0, WB_NONE, 1'b0, 1'b0);
                6'd30: u = mk(1'b0, OPA_NONE, OPB_NONE, 1'b1, 1'b1, 1'b0, WB_NONE, 1'b0, 1'b0);
                6'd31: u = mk(1'b0, OPA_NONE, OPB_NONE, 1'b0, 1'b0, 1'b0, WB_INT, 1'b0, 1'b0);
                6'd32: u = mk(1'b1, OPA_KP, OPB_ERR, 1'b0, 1'b0, 1'b0, WB_NONE, 1'b0, 1'b0);
                6'd33: u = mk(1'b0, OPA_NONE, OPB_NONE, 1'b1, 1'b1, 1'b0, WB_NONE, 1'b0, 1'b0);
                6'd34: u = mk(1'b0, OPA_NONE, OPB_NONE, 1'b0, 1'b0, 1'b0, WB_FREQ, 1'b0, 1'b0);
                6'd35: u = mk(1'b1, OPA_FREQ, OPB_PER, 1'b0, 1'b0, 1'b0, WB_NONE, 1'b0, 1'b0);
                6'd36: u = mk(1'b0, OPA_NONE, OPB_NONE, 1'b1, 1'b1, 1'b0, WB_NONE, 1'b0, 1'b0);
                6'd37: u = mk(1'b0, OPA_NONE, OPB_NONE, 1'b0, 1'b0, 1'b0, WB_PHASE, 1'b0, 1'b0);
                6'd38: u = mk(1'b0, OPA_NONE, OPB_NONE, 1'b0, 1'b0, 1'b0, WB_SIN, 1'b0, 1'b0);
                6'd39: u = mk(1'b0, OPA_NONE, OPB_NONE, 1'b0, 1'b0, 1'b0, WB_COS, 1'b0, 1'b0);
                6'd40: u = mk(1'b0, OPA_NONE, OPB_NONE, 1'b0, 1'b0, 1'b0, WB_NONE, 1'b0, 1'b1);
                default: u = UOP_NOP;
            endcase
        end
        return u;
    endfunction

    // Sine of a Q0.32 turn angle in Q1.15; only evaluated on constants
    // to build the lookup table.
    function automatic logic signed [15:0] sine_turn(input logic [31:0] t);
        longint unsigned r;
        longint unsigned x;
        longint unsigned x2;
        longint unsigned acc;
        longint unsigned v;
        logic [1:0]      quad;
        quad = t[31:30];
        r = {34'd0, t[29:0]};
        if (quad[0]) begin
            r = ONE_Q30 - r;
        end
        x   = (r * HALF_PI_Q30) >> 30;
        x2  = (x * x) >> 30;
        acc = ONE_Q30;
        acc = ONE_Q30 - ((x2 * acc) >> 30) / 64'd110;
        acc = ONE_Q30 - ((x2 * acc) >> 30) / 64'd72;
        acc = ONE_Q30 - ((x2 * acc) >> 30) / 64'd42;
        acc = ONE_Q30 - ((x2 * acc) >> 30) / 64'd20;
        acc = ONE_Q30 - ((x2 * acc) >> 30) / 64'd6;
        v = (((x * acc) >> 30) + 64'd16384) >> 15;
        if (v > 64'd32767) begin
            v = 64'd32767;
        end
        return quad[1] ? -$signed(v[15:0]) : $signed(v[15:0]);
    endfunction

    function automatic logic signed [31:0] sat32(input logic signed [ACC_W-1:0] v);
        logic [ACC_W-32:0] top;
        top = v[ACC_W-1:31];
        if (&top || ~|top) begin
            return v[31:0];
        end
        return v[ACC_W-1] ? 32'sh80000000 : 32'sh7fffffff;
    endfunction

    function automatic logic signed [SAMPLE_WIDTH-1:0] sat_smp(
        input logic signed [ACC_W-1:0] v);
        logic [ACC_W-SAMPLE_WIDTH:0] top;
        top = v[ACC_W-1:SAMPLE_WIDTH-1];
        if (&top || ~|top) begin
            return v[SAMPLE_WIDTH-1:0];
        end
        return v[ACC_W-1] ? {1'b1, {(SAMPLE_WIDTH-1){1'b0}}}
                          : {1'b0, {(SAMPLE_WIDTH-1){1'b1}}};
    endfunction

endpackage

// ===== rtl/tgpll_ctrl.sv =====
// Sequencer of the grid PLL: steps the microcode and runs the item handshakes.
// Depends on tgpll_pkg.
module tgpll_ctrl
    import tgpll_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    output logic o_in_stall,
    output logic o_out_valid,
    input  logic i_out_stall,
    output t_cmd o_cmd
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_RUN  = 2'd1;
    localparam logic [1:0] ST_HOLD = 2'd2;

    logic [1:0]        r_state, n_state;
    logic [STEP_W-1:0] r_step, n_step;
    logic              r_out_valid, n_out_valid;
    t_uop              w_uop;
    logic              w_out_free;
    logic              w_done;

    assign w_uop      = ucode(r_step);
    assign w_out_free = !r_out_valid || !i_out_stall;
    assign w_done     = (r_state == ST_HOLD) || (r_state == ST_RUN && w_uop.last);

    always_comb begin
        n_state     = r_state;
        n_step      = r_step;
        n_out_valid = r_out_valid && i_out_stall;
        o_cmd.load_in  = 1'b0;
        o_cmd.out_load = w_done && w_out_free;
        o_cmd.uop      = (r_state == ST_RUN) ? w_uop : UOP_NOP;
        unique case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load_in = 1'b1;
                    n_state = ST_RUN;
                    n_step  = '0;
                end
            end
            ST_RUN: begin
                if (w_uop.last) begin
                    n_state = w_out_free ? ST_IDLE : ST_HOLD;
                end else begin
                    n_step = r_step + 1'b1;
                end
            end
            ST_HOLD: begin
                if (w_out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
        if (o_cmd.out_load) begin
            n_out_valid = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_step      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_step      <= n_step;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_in_stall  = (r_state != ST_IDLE);
    assign o_out_valid = r_out_valid;

endmodule

// ===== rtl/tgpll_dp.sv =====
// Datapath of the grid PLL: config registers, shared multiplier and accumulator,
// loop state, sine table and result register. Depends on tgpll_pkg.
module tgpll_dp
    import tgpll_pkg::*;
#(
    parameter int SINE_TABLE_DEPTH = 256
)(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  t_cmd                 i_cmd,
    input  t_in_item             i_in_data,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [31:0]          i_cfg_data,
    output t_out_item            o_out_data
);

    localparam int SW     = SAMPLE_WIDTH;
    localparam int TAB_AW = $clog2(SINE_TABLE_DEPTH);

    logic signed [31:0] r_b0, r_b1, r_b2, r_a1, r_a2, r_kp, r_ki;
    logic [31:0]        r_per;

    logic signed [SW-1:0]   r_va, r_vb, r_vc;
    logic signed [SW:0]     r_beta;
    logic signed [31:0]     r_ad1, r_ad2, r_bd1, r_bd2;
    logic signed [31:0]     r_w0, r_ua, r_ub, r_integ, r_freq;
    logic signed [SW-1:0]   r_d, r_q;
    logic signed [SW:0]     r_err;
    logic [31:0]            r_phase;
    logic signed [15:0]     r_sin, r_cos;
    logic signed [PROD_W-1:0] r_prod;
    logic signed [ACC_W-1:0]  r_acc;
    t_out_item              r_out;

    logic signed [SW:0]     w_diff;
    logic signed [31:0]     w_d1, w_d2;
    logic signed [OP_W-1:0] w_opa, w_opb;
    logic signed [ACC_W-1:0] w_prod_ext;
    logic signed [ACC_W-1:0] w_rnd30, w_rnd15, w_rnd16, w_rndg, w_x;
    logic [TAB_AW-1:0]      w_idx;
    logic signed [15:0]     w_tab_rd;
    logic signed [15:0]     w_tab [SINE_TABLE_DEPTH];

    // sine table, built from constants at elaboration
    for (genvar g = 0; g < SINE_TABLE_DEPTH; g++) begin : g_tab
        assign w_tab[g] = sine_turn(32'(g) << (32 - TAB_AW));
    end

    assign w_diff = {r_vb[SW-1], r_vb} - {r_vc[SW-1], r_vc};
    assign w_d1   = i_cmd.uop.ch ? r_bd1 : r_ad1;
    assign w_d2   = i_cmd.uop.ch ? r_bd2 : r_ad2;

    always_comb begin
        unique case (i_cmd.uop.opa)
            OPA_DIFF: w_opa = OP_W'(w_diff);
            OPA_A1:   w_opa = OP_W'(r_a1);
            OPA_A2:   w_opa = OP_W'(r_a2);
            OPA_B0:   w_opa = OP_W'(r_b0);
            OPA_B1:   w_opa = OP_W'(r_b1);
            OPA_B2:   w_opa = OP_W'(r_b2);
            OPA_UA:   w_opa = OP_W'(r_ua);
            OPA_UB:   w_opa = OP_W'(r_ub);
            OPA_KI:   w_opa = OP_W'(r_ki);
            OPA_KP:   w_opa = OP_W'(r_kp);
            OPA_FREQ: w_opa = OP_W'(r_freq);
            default:  w_opa = '0;
        endcase
        unique case (i_cmd.uop.opb)
            OPB_ISQ3: w_opb = $signed({{(OP_W-17){1'b0}}, INV_SQRT3_Q16});
            OPB_D1:   w_opb = OP_W'(w_d1);
            OPB_D2:   w_opb = OP_W'(w_d2);
            OPB_W0:   w_opb = OP_W'(r_w0);
            OPB_COS:  w_opb = OP_W'(r_cos);
            OPB_SIN:  w_opb = OP_W'(r_sin);
            OPB_ERR:  w_opb = OP_W'(r_err);
            OPB_PER:  w_opb = $signed({1'b0, r_per});
            default:  w_opb = '0;
        endcase
    end

    // rounding taps on the accumulator: floor(acc / 2^n + 1/2)
    assign w_prod_ext = ACC_W'(r_prod);
    assign w_rnd30 = (r_acc + (ACC_W'(1) << 29)) >>> 30;
    assign w_rnd15 = (r_acc + (ACC_W'(1) << 14)) >>> 15;
    assign w_rnd16 = (r_acc + (ACC_W'(1) << 15)) >>> 16;
    assign w_rndg  = (r_acc + (ACC_W'(1) << (GAIN_SH - 1))) >>> GAIN_SH;
    assign w_x     = i_cmd.uop.ch ? ACC_W'(r_beta) : ACC_W'(r_va);

    assign w_idx    = (i_cmd.uop.wb == WB_COS)
                      ? r_phase[31 -: TAB_AW] + TAB_AW'(SINE_TABLE_DEPTH / 4)
                      : r_phase[31 -: TAB_AW];
    assign w_tab_rd = w_tab[w_idx];

    // config registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b0 <= '0; r_b1 <= '0; r_b2 <= '0; r_a1 <= '0;
            r_a2 <= '0; r_kp <= '0; r_ki <= '0; r_per <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_B0:  r_b0  <= i_cfg_data;
                CFG_B1:  r_b1  <= i_cfg_data;
                CFG_B2:  r_b2  <= i_cfg_data;
                CFG_A1:  r_a1  <= i_cfg_data;
                CFG_A2:  r_a2  <= i_cfg_data;
                CFG_KP:  r_kp  <= i_cfg_data;
                CFG_KI:  r_ki  <= i_cfg_data;
                CFG_PER: r_per <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // loop state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ad1 <= '0; r_ad2 <= '0; r_bd1 <= '0; r_bd2 <= '0;
            r_integ <= '0;
            r_phase <= '0;
            r_sin   <= '0;
            r_cos   <= COS_RESET;
        end else begin
            unique case (i_cmd.uop.wb)
                WB_Y: begin
                    if (i_cmd.uop.ch) begin
                        r_bd2 <= r_bd1;
                        r_bd1 <= r_w0;
                    end else begin
                        r_ad2 <= r_ad1;
                        r_ad1 <= r_w0;
                    end
                end
                WB_INT:   r_integ <= sat32(r_integ + w_rndg);
                WB_PHASE: r_phase <= r_phase - w_rnd16[31:0];
                WB_SIN:   r_sin   <= w_tab_rd;
                WB_COS:   r_cos   <= w_tab_rd;
                default: ;
            endcase
        end
    end

    // working registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_in) begin
            r_va <= i_in_data.phase_a;
            r_vb <= i_in_data.phase_b;
            r_vc <= i_in_data.phase_c;
        end
        if (i_cmd.uop.mul_en) begin
            r_prod <= w_opa * w_opb;
        end
        if (i_cmd.uop.acc_en) begin
            r_acc <= (i_cmd.uop.acc_clr ? '0 : r_acc)
                   + (i_cmd.uop.acc_sub ? -w_prod_ext : w_prod_ext);
        end
        unique case (i_cmd.uop.wb)
            WB_BETA: r_beta <= w_rnd16[SW:0];
            WB_W0:   r_w0   <= sat32(w_x - w_rnd30);
            WB_Y: begin
                if (i_cmd.uop.ch) begin
                    r_ub <= sat32(w_rnd30);
                end else begin
                    r_ua <= sat32(w_rnd30);
                end
            end
            WB_D:    r_d <= sat_smp(w_rnd15);
            WB_Q: begin
                r_q   <= sat_smp(w_rnd15);
                r_err <= -((SW+1)'(sat_smp(w_rnd15)));
            end
            WB_FREQ: r_freq <= sat32(w_rndg + ACC_W'(r_integ));
            default: ;
        endcase
        if (i_cmd.out_load) begin
            r_out.direct_axis        <= r_d;
            r_out.quadrature_axis    <= r_q;
            r_out.frequency_estimate <= r_freq;
            r_out.phase_angle        <= r_phase[31:16];
            r_out.sine_out           <= r_sin;
            r_out.cosine_out         <= r_cos;
        end
    end

    assign o_out_data = r_out;

endmodule

// ===== rtl/three_phase_grid_pll.sv =====
// Top level of the three-phase grid PLL: sequencer plus datapath.
// Depends on tgpll_pkg, tgpll_ctrl and tgpll_dp.
//
// Usage:
//  - Input channel (i_in_valid / o_in_stall / i_in_data): one item is one
//    three-phase sample (phase_a, phase_b, phase_c), Q1.15.
//  - Output channel (o_out_valid / i_out_stall / o_out_data): one item per
//    input item with d, q, frequency (Q16.16), phase angle, sine and cosine.
//  - Config channel (i_cfg_valid / o_cfg_ready / i_cfg_index / i_cfg_data):
//    ready is always high; write only while the block is idle.
//  - The result is loaded into the output register at the last microcode step.
//  - The sequence of 41 microcode steps on one shared 33x33 multiplier sets
//    the item rate; a new item is taken only once the previous one finishes.
//  - The input stalls while an item is in work; the output register lets the
//    next item start while the previous result waits.
//  - If the receiver stalls, a finished item waits in the sequencer until
//    the output register frees; no further input is taken meanwhile.
//  - Reset (synchronous, active low) clears config, filter delays,
//    integrator and phase; cosine restarts at full scale, sine at zero.
module three_phase_grid_pll
    import tgpll_pkg::*;
#(
    parameter int SINE_TABLE_DEPTH = 256
)(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  t_in_item             i_in_data,
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output t_out_item            o_out_data,
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [31:0]          i_cfg_data
);

    t_cmd w_cmd;

    assign o_cfg_ready = 1'b1;

    tgpll_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_cmd       (w_cmd)
    );

    tgpll_dp #(
        .SINE_TABLE_DEPTH (SINE_TABLE_DEPTH)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (w_cmd),
        .i_in_data   (i_in_data),
        .i_cfg_we    (i_cfg_valid && o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_out_data  (o_out_data)
    );

endmodule

// ===== rtl/tgpll_chk.sv =====
// Port-level checks of the grid PLL and their bind to the top level.
// Depends on three_phase_grid_pll.
module tgpll_chk (
    input logic i_clk,
    input logic i_rst_n,
    input logic i_in_valid,
    input logic o_in_stall,
    input logic o_out_valid,
    input logic i_out_stall,
    input logic o_cfg_ready
);

    // a stalled result stays offered
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid)
        else $error("result dropped while stalled");

    // a taken item keeps the block busy
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall |=> o_in_stall)
        else $error("input open right after an item");

    // reset empties output and opens input
    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid && !o_in_stall)
        else $error("bad state after reset");

    a_cfg_ready: assert property (@(posedge i_clk) o_cfg_ready)
        else $error("config port not ready");

endmodule

bind three_phase_grid_pll tgpll_chk u_chk (.*);
